>>> rtl/core/obt_pkg.sv
package obt_pkg;

   localparam int TableDepth = 16;
   localparam int SlotW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_LEFT_MARGIN  = 3'd1;
   localparam logic [2:0] CSR_RIGHT_MARGIN = 3'd2;
   localparam logic [2:0] CSR_MIN_AREA     = 3'd3;
   localparam logic [2:0] CSR_MEDIUM_AREA  = 3'd4;
   localparam logic [2:0] CSR_LARGE_AREA   = 3'd5;

   localparam logic [2:0] ST_TOO_SMALL = 3'd0;
   localparam logic [2:0] ST_OUTSIDE   = 3'd1;
   localparam logic [2:0] ST_INSIDE    = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_SWEPT     = 3'd4;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [12:0] w;
      logic [12:0] h;
   } box_type;

   // travels down the chain of cells, one cell per cycle
   typedef struct packed {
      logic        sweep;
      box_type     box;
      logic [25:0] area;
      logic        hit;
      logic [31:0] hit_id;
      logic [SlotW-1:0] hit_slot;
      logic        hit_inside;
      logic        free;
      logic [SlotW-1:0] free_slot;
      logic [CntW-1:0] evicted;
   } token_type;

   // write-back command broadcast to all cells after the walk
   typedef struct packed {
      logic        en;
      logic        sweep;
      logic [SlotW-1:0] slot;
      logic        alloc;
      logic [31:0] id;
      box_type     box;
      logic        in_margin;
   } wb_type;

endpackage

>>> rtl/core/overlap_box_tracker.sv
// Overlap box tracker.
// Input channel req_*: one item is a detection box (req_mode 0) or an
// end-of-frame sweep (req_mode 1), accepted when req_valid is high and
// req_stall is low. Each item yields exactly one result on rsp_*, taken
// when rsp_valid is high and rsp_stall is low.
// A detection walks a chain of 16 table cells, one cell per cycle, then
// writes back; the result is registered in the output register at the
// write-back. A sweep uses the same walk. Items are handled one at a time;
// the next item is accepted as soon as the current result is in the output
// register, even while that result is stalled.
// Detection boxes with area below min_area skip the walk; their result comes from S_HOLD.
// csr_* writes registers at any edge with csr_we; write only when idle.
// Reset (synchronous) clears all table entries, the ID counter and
// restores register defaults. While rsp_stall is high the result holds and
// at most one further item is processed up to its write-back.
module overlap_box_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [11:0] req_box_x,
   input  logic [11:0] req_box_y,
   input  logic [12:0] req_box_w,
   input  logic [12:0] req_box_h,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_object_id,
   output logic        rsp_is_new,
   output logic [1:0]  rsp_size_class,
   output logic [4:0]  rsp_evicted_count,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   import obt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_DONE = 4'b0100,
      S_HOLD = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [12:0] fw_ff;
   logic [11:0] lm_ff;
   logic [12:0] rm_ff;
   logic [24:0] min_ff, med_ff, lrg_ff;
   logic [31:0] idc_ff;
   logic [SlotW:0] step_ff;
   token_type head_ff;
   token_type chain [TableDepth+1];
   wb_type wb;
   logic active;

   logic [2:0]  r_status_ff, r_status_in;
   logic [31:0] r_id_ff, r_id_in;
   logic        r_new_ff, r_new_in;
   logic [1:0]  r_cls_ff, r_cls_in;
   logic [4:0]  r_ev_ff, r_ev_in;
   logic        rsp_valid_ff;
   logic [1:0]  cls_ff;
   logic        inside_now_ff;

   logic [25:0] area_c;
   logic [13:0] rend_c;
   logic        accept, out_free;
   logic [1:0]  cls_c;

   assign area_c = req_box_w * req_box_h;
   assign rend_c = {2'b0, req_box_x} + {1'b0, req_box_w};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign active = (state_ff == S_WALK);

   always_comb begin
      if (area_c >= {1'b0, min_ff} && area_c < {1'b0, med_ff}) cls_c = 2'd1;
      else if (area_c >= {1'b0, med_ff} && area_c < {1'b0, lrg_ff}) cls_c = 2'd2;
      else if (area_c >= {1'b0, lrg_ff}) cls_c = 2'd3;
      else cls_c = 2'd0;
   end

   assign chain[0] = head_ff;
   genvar g;
   generate
      for (g = 0; g < TableDepth; g++) begin : g_cell
         obt_cell u_cell (
            .clock(clock), .reset(reset), .active(active),
            .frame_width(fw_ff), .tok_in(chain[g]), .tok_out(chain[g+1]),
            .wb(wb), .my_slot(SlotW'(g))
         );
      end
   endgenerate

   token_type fin;
   assign fin = chain[TableDepth];

   always_comb begin
      wb = '0;
      r_status_in = ST_TOO_SMALL;
      r_id_in = '0;
      r_new_in = 1'b0;
      r_cls_in = '0;
      r_ev_in = '0;
      wb.box = fin.box;
      if (fin.sweep) begin
         wb.en = 1'b1;
         wb.sweep = 1'b1;
         r_status_in = ST_SWEPT;
         r_ev_in = 5'(fin.evicted);
      end else begin
         r_cls_in = cls_ff;
         if (fin.hit) begin
            wb.en = 1'b1;
            wb.slot = fin.hit_slot;
            wb.in_margin = fin.hit_inside | inside_now_ff;
            r_id_in = fin.hit_id;
         end else if (fin.free) begin
            wb.en = 1'b1;
            wb.slot = fin.free_slot;
            wb.alloc = 1'b1;
            wb.id = idc_ff + 32'd1;
            wb.in_margin = inside_now_ff;
            r_id_in = idc_ff + 32'd1;
            r_new_in = 1'b1;
         end else begin
            r_status_in = ST_FULL;
         end
         if (wb.en) r_status_in = wb.in_margin ? ST_INSIDE : ST_OUTSIDE;
      end
      if (state_ff != S_DONE || !out_free) wb.en = 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            if (!req_mode && area_c < {1'b0, min_ff}) state_in = S_HOLD;
            else state_in = S_WALK;
         end
         S_WALK: if (step_ff == (SlotW+1)'(TableDepth - 1)) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         S_HOLD: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fw_ff <= 13'd640;
         lm_ff <= 12'd64;
         rm_ff <= 13'd576;
         min_ff <= 25'd100;
         med_ff <= 25'd1000;
         lrg_ff <= 25'd3000;
         idc_ff <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff <= csr_wdata[12:0];
               CSR_LEFT_MARGIN:  lm_ff <= csr_wdata[11:0];
               CSR_RIGHT_MARGIN: rm_ff <= csr_wdata[12:0];
               CSR_MIN_AREA:     min_ff <= csr_wdata;
               CSR_MEDIUM_AREA:  med_ff <= csr_wdata;
               CSR_LARGE_AREA:   lrg_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) step_ff <= '0;
         else if (active) step_ff <= step_ff + 1'b1;
         if (wb.en && wb.alloc) idc_ff <= wb.id;
         if ((state_ff == S_DONE || state_ff == S_HOLD) && out_free)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         head_ff <= '{sweep: req_mode,
                      box: '{x: req_box_x, y: req_box_y, w: req_box_w, h: req_box_h},
                      area: area_c,
                      default: '0};
         cls_ff <= cls_c;
         inside_now_ff <= (req_box_x > lm_ff) && (rend_c < {1'b0, rm_ff});
      end
      if (state_ff == S_DONE && out_free) begin
         r_status_ff <= r_status_in;
         r_id_ff <= r_id_in;
         r_new_ff <= r_new_in;
         r_cls_ff <= r_cls_in;
         r_ev_ff <= r_ev_in;
      end else if (state_ff == S_HOLD && out_free) begin
         r_status_ff <= ST_TOO_SMALL;
         r_id_ff <= '0;
         r_new_ff <= 1'b0;
         r_cls_ff <= '0;
         r_ev_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = r_status_ff;
   assign rsp_object_id = r_id_ff;
   assign rsp_is_new = r_new_ff;
   assign rsp_size_class = r_cls_ff;
   assign rsp_evicted_count = r_ev_ff;
endmodule

>>> rtl/core/obt_cell.sv
module obt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              active,
   input  logic [12:0]       frame_width,
   input  obt_pkg::token_type tok_in,
   output obt_pkg::token_type tok_out,
   input  obt_pkg::wb_type    wb,
   input  logic [obt_pkg::SlotW-1:0] my_slot
);
   import obt_pkg::*;

   logic        valid_ff, valid_in;
   logic        inside_ff, inside_in;
   logic [31:0] id_ff;
   box_type     box_ff;
   token_type   pass_ff, pass_in;
   logic [12:0] ox_lo, ox_hi, oy_lo, oy_hi, ow, oh;
   logic [13:0] a_end, b_end;
   logic [13:0] c_end, d_end;
   logic [25:0] ov;

   always_comb begin
      a_end = {2'b0, box_ff.x} + {1'b0, box_ff.w};
      b_end = {2'b0, tok_in.box.x} + {1'b0, tok_in.box.w};
      c_end = {2'b0, box_ff.y} + {1'b0, box_ff.h};
      d_end = {2'b0, tok_in.box.y} + {1'b0, tok_in.box.h};
      ox_lo = {1'b0, (box_ff.x > tok_in.box.x) ? box_ff.x : tok_in.box.x};
      ox_hi = (a_end < b_end) ? a_end[12:0] : b_end[12:0];
      oy_lo = {1'b0, (box_ff.y > tok_in.box.y) ? box_ff.y : tok_in.box.y};
      oy_hi = (c_end < d_end) ? c_end[12:0] : d_end[12:0];
      ow = (ox_hi > ox_lo) ? ox_hi - ox_lo : 13'd0;
      oh = (oy_hi > oy_lo) ? oy_hi - oy_lo : 13'd0;
      ov = ow * oh;
      pass_in = tok_in;
      if (tok_in.sweep) begin
         if (valid_ff && a_end >= {1'b0, frame_width})
            pass_in.evicted = tok_in.evicted + 1'b1;
      end else if (valid_ff) begin
         if ({ov, 1'b0} > {1'b0, tok_in.area}
             && (!tok_in.hit || id_ff < tok_in.hit_id)) begin
            pass_in.hit = 1'b1;
            pass_in.hit_id = id_ff;
            pass_in.hit_slot = my_slot;
            pass_in.hit_inside = inside_ff;
         end
      end else if (!tok_in.free) begin
         pass_in.free = 1'b1;
         pass_in.free_slot = my_slot;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      inside_in = inside_ff;
      if (wb.en && wb.sweep) begin
         if (valid_ff && a_end >= {1'b0, frame_width}) begin
            valid_in = 1'b0;
            inside_in = 1'b0;
         end
      end else if (wb.en && wb.slot == my_slot) begin
         valid_in = 1'b1;
         inside_in = wb.in_margin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         inside_ff <= inside_in;
      end
      if (wb.en && !wb.sweep && wb.slot == my_slot) begin
         box_ff <= wb.box;
         if (wb.alloc) id_ff <= wb.id;
      end
      if (active) pass_ff <= pass_in;
   end

   assign tok_out = pass_ff;
endmodule
